// ===== src/assert_macros.svh =====
// Assertion macros used by the scheduler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TRSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication checked in the same cycle outside reset.
`define TRSS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/trss_pkg.sv =====
// Shared types, codes and constants of the transmit ring segment scheduler.
package trss_pkg;

    localparam int RING_DEPTH_DEF    = 512;
    localparam int REQUEST_SLOTS_DEF = 8;

    localparam int LEN_W    = 9;
    localparam int TAG_W    = 8;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int FIELD9_W = 9;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] COALESCE_RESET = 9'd32;

    // Register index decoded from paddr[2].
    localparam logic [0:0] REG_COALESCE = 1'b0;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_DONE  = 2'd1;
    localparam logic [OP_W-1:0] OP_KICK  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTICE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LAUNCH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO_LEN = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [LEN_W-1:0] length;
        logic [TAG_W-1:0] tag;
        logic             want_notice;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STAT_W-1:0]   status_code;
        logic [TAG_W-1:0]    notice_tag;
        logic [FIELD9_W-1:0] segment_start;
        logic [FIELD9_W-1:0] segment_length;
        logic [FIELD9_W-1:0] pending_count;
        logic                transfer_busy;
        logic                last;
    } res_t;

    // One queued write request.
    typedef struct packed {
        logic             want;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] remaining;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LAUNCH_EVAL,
        S_RET_RD,
        S_RET_CHK,
        S_EMIT_LAUNCH,
        S_EMIT_STATUS
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic launch_eval;
        logic ret_step;
        logic emit_launch;
        logic emit_status;
    } cmd_t;

    typedef struct packed {
        logic is_done_op;
        logic retire_more;
        logic notice_due;
        logic launch_flag;
        logic out_free;
    } sts_t;

endpackage

// ===== src/trss_ctrl.sv =====
// Sequencing state machine of the transmit ring segment scheduler.
module trss_ctrl import trss_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_LAUNCH_EVAL;
            end
            S_LAUNCH_EVAL: begin
                state_next = sts.is_done_op ? S_RET_RD : S_EMIT_LAUNCH;
            end
            S_RET_RD: begin
                state_next = sts.retire_more ? S_RET_CHK : S_EMIT_LAUNCH;
            end
            S_RET_CHK: begin
                if (!sts.notice_due || sts.out_free) state_next = S_RET_RD;
            end
            S_EMIT_LAUNCH: begin
                if (!sts.launch_flag || sts.out_free) state_next = S_EMIT_STATUS;
            end
            S_EMIT_STATUS: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
            end
            S_LAUNCH_EVAL: begin
                cmd.launch_eval = 1'b1;
            end
            S_RET_RD: begin
            end
            S_RET_CHK: begin
                // A due notice waits for room in the output register.
                cmd.ret_step = !sts.notice_due || sts.out_free;
            end
            S_EMIT_LAUNCH: begin
                cmd.emit_launch = sts.launch_flag && sts.out_free;
            end
            S_EMIT_STATUS: begin
                cmd.emit_status = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/trss_dp.sv =====
// Pointer, request queue and result datapath of the transmit ring segment scheduler.
`include "assert_macros.svh"

module trss_dp import trss_pkg::*; #(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int REQUEST_SLOTS = REQUEST_SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  req_t             s_data,
    input  logic [LEN_W-1:0] coalesce_threshold,
    output logic             m_valid,
    input  logic             m_ready,
    output res_t             m_data
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int Q_W   = $clog2(REQUEST_SLOTS);

    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);
    localparam logic [Q_W-1:0]   Q_LAST  = Q_W'(REQUEST_SLOTS - 1);

    // Held request and step results.
    req_t              req_reg;
    logic [STAT_W-1:0] code_reg, code_next;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] active_len_reg, active_len_next;
    logic [CNT_W-1:0] sent_reg, sent_next;
    logic [Q_W-1:0]   head_reg, head_next;
    logic [Q_W-1:0]   tail_reg, tail_next;

    logic             launch_flag_reg, launch_flag_next;
    logic [PTR_W-1:0] seg_start_reg, seg_start_next;
    logic [CNT_W-1:0] seg_len_reg, seg_len_next;

    logic m_valid_reg, m_valid_next;
    res_t m_data_reg, m_data_next;

    entry_t req_mem [REQUEST_SLOTS];
    entry_t rd_entry_reg;
    logic             mem_we;
    logic [Q_W-1:0]   mem_addr;
    entry_t           mem_wdata;

    logic [SUM_W-1:0] wp_s, rp_s, count_s, space_s, contig_s, len_s, sum_s;
    logic [SUM_W-1:0] sent_s, rem_s;
    logic             nowrap, len_ok, q_full, launch_ok, hold, out_free, out_load;
    logic [Q_W-1:0]   head_inc, tail_inc;

    always_comb begin
        wp_s    = SUM_W'(wp_reg);
        rp_s    = SUM_W'(rp_reg);
        nowrap  = wp_reg >= rp_reg;
        count_s = nowrap ? (wp_s - rp_s) : (wp_s + DEPTH_S - rp_s);
        space_s = DEPTH_S - SUM_W'(1) - count_s;
        contig_s = nowrap ? (wp_s - rp_s) : (DEPTH_S - rp_s);
        len_s   = SUM_W'(req_reg.length);
        len_ok  = (req_reg.length != '0) && (len_s <= space_s);
        head_inc = (head_reg == Q_LAST) ? '0 : head_reg + 1'b1;
        tail_inc = (tail_reg == Q_LAST) ? '0 : tail_reg + 1'b1;
        q_full  = head_inc == tail_reg;
        sent_s  = SUM_W'(sent_reg);
        rem_s   = SUM_W'(rd_entry_reg.remaining);
        // Short non-wrapping segments wait for more data unless kicked or the threshold is zero.
        hold = (req_reg.opcode != OP_KICK) && (coalesce_threshold != '0) && nowrap &&
               (contig_s < SUM_W'(coalesce_threshold));
        launch_ok = ((req_reg.opcode == OP_WRITE && code_reg == STAT_OK) ||
                     req_reg.opcode == OP_DONE || req_reg.opcode == OP_KICK) &&
                    !busy_reg && (rp_reg != wp_reg) && !hold;
    end

    // Next state of the ring and queue bookkeeping.
    always_comb begin
        code_next        = code_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        busy_next        = busy_reg;
        active_len_next  = active_len_reg;
        sent_next        = sent_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        launch_flag_next = launch_flag_reg;
        seg_start_next   = seg_start_reg;
        seg_len_next     = seg_len_reg;
        mem_we           = 1'b0;
        mem_addr         = head_reg;
        mem_wdata        = '{want: req_reg.want_notice, tag: req_reg.tag,
                             remaining: req_reg.length};
        sum_s            = '0;

        if (cmd.exec) begin
            code_next = STAT_OK;
            if (req_reg.opcode == OP_WRITE) begin
                if (req_reg.length == '0) begin
                    code_next = STAT_ZERO_LEN;
                end else if (!len_ok) begin
                    code_next = STAT_NO_SPACE;
                end else begin
                    sum_s   = wp_s + len_s;
                    wp_next = PTR_W'((sum_s >= DEPTH_S) ? (sum_s - DEPTH_S) : sum_s);
                    if (!q_full) begin
                        mem_we    = 1'b1;
                        head_next = head_inc;
                    end
                end
            end else if (req_reg.opcode == OP_DONE) begin
                sum_s           = rp_s + SUM_W'(active_len_reg);
                rp_next         = PTR_W'((sum_s >= DEPTH_S) ? (sum_s - DEPTH_S) : sum_s);
                sent_next       = active_len_reg;
                active_len_next = '0;
                busy_next       = 1'b0;
            end
        end

        if (cmd.launch_eval) begin
            launch_flag_next = launch_ok;
            if (launch_ok) begin
                busy_next       = 1'b1;
                active_len_next = CNT_W'(contig_s);
                seg_start_next  = rp_reg;
                seg_len_next    = CNT_W'(contig_s);
            end
        end

        if (cmd.ret_step) begin
            if (sent_s >= rem_s) begin
                sent_next = CNT_W'(sent_s - rem_s);
                tail_next = tail_inc;
            end else begin
                // Partly covered request keeps its remainder at the tail.
                mem_we    = 1'b1;
                mem_addr  = tail_reg;
                mem_wdata = '{want: rd_entry_reg.want, tag: rd_entry_reg.tag,
                              remaining: LEN_W'(rem_s - sent_s)};
                sent_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            busy_reg        <= 1'b0;
            active_len_reg  <= '0;
            sent_reg        <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            launch_flag_reg <= 1'b0;
            code_reg        <= STAT_OK;
            m_valid_reg     <= 1'b0;
        end else begin
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            busy_reg        <= busy_next;
            active_len_reg  <= active_len_next;
            sent_reg        <= sent_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            launch_flag_reg <= launch_flag_next;
            code_reg        <= code_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) req_reg <= s_data;
        seg_start_reg <= seg_start_next;
        seg_len_reg   <= seg_len_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) req_mem[mem_addr] <= mem_wdata;
        rd_entry_reg <= req_mem[tail_reg];
    end

    // Output register; every result carries the end-of-step count and busy flag.
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        out_load = cmd.emit_launch || cmd.emit_status ||
                   (cmd.ret_step && sts.notice_due);

        m_data_next                = m_data_reg;
        m_data_next.status_code    = STAT_OK;
        m_data_next.notice_tag     = '0;
        m_data_next.segment_start  = '0;
        m_data_next.segment_length = '0;
        m_data_next.pending_count  = FIELD9_W'(count_s);
        m_data_next.transfer_busy  = busy_reg;
        m_data_next.last           = 1'b0;
        m_data_next.kind           = KIND_NOTICE;
        if (cmd.emit_status) begin
            m_data_next.kind        = KIND_STATUS;
            m_data_next.status_code = code_reg;
            m_data_next.last        = 1'b1;
        end else if (cmd.emit_launch) begin
            m_data_next.kind           = KIND_LAUNCH;
            m_data_next.segment_start  = FIELD9_W'(seg_start_reg);
            m_data_next.segment_length = FIELD9_W'(seg_len_reg);
        end else begin
            m_data_next.notice_tag = rd_entry_reg.tag;
        end
        if (!out_load) m_data_next = m_data_reg;

        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_comb begin
        sts.is_done_op  = req_reg.opcode == OP_DONE;
        sts.retire_more = (sent_reg != '0) && (tail_reg != head_reg);
        sts.notice_due  = (sent_s >= rem_s) && rd_entry_reg.want;
        sts.launch_flag = launch_flag_reg;
        sts.out_free    = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `TRSS_ASSERT_IMPL(a_load_into_free, out_load, out_free, "result loaded over a waiting result")
    `TRSS_ASSERT_IMPL(a_busy_has_len, busy_reg, active_len_reg != '0, "busy with empty segment")
    `TRSS_ASSERT(a_ptr_range, (wp_s < DEPTH_S) && (rp_s < DEPTH_S), "ring pointer out of range")

endmodule

// ===== src/tx_ring_segment_scheduler_unit.sv =====
// Top level of the transmit ring segment scheduler with its APB register.
//
//   channel   direction   handshake          payload
//   s_        in          s_valid/s_ready    req_t: opcode, length, tag, want_notice
//   m_        out         m_valid/m_ready    res_t: kind ... last
//   apb       in/out      psel/penable       coalesce_threshold at byte address 0
//
// A request is taken only in the idle state and occupies the block until its status
// result is loaded; a done event also walks the queued requests it covers, since the
// retire loop reads the request queue memory one entry per step.
// Results leave through a one-entry output register; a stalled m_ready holds the
// sequence at its next result. Reset is synchronous and needs no clearing pass.
module tx_ring_segment_scheduler_unit import trss_pkg::*; #(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int REQUEST_SLOTS = REQUEST_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_t                  m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cmd_t cmd;
    sts_t sts;

    logic [LEN_W-1:0] coalesce_reg;
    logic [0:0]       reg_index;

    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coalesce_reg <= COALESCE_RESET;
        end else if (psel && penable && pwrite && reg_index == REG_COALESCE) begin
            coalesce_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (reg_index == REG_COALESCE) ? APB_DATA_W'(coalesce_reg) : '0;

    trss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    trss_dp #(
        .RING_DEPTH    (RING_DEPTH),
        .REQUEST_SLOTS (REQUEST_SLOTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_data             (s_data),
        .coalesce_threshold (coalesce_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data)
    );

endmodule
